// File: design/fcsc_pkg.sv
// Shared types, codes and constants for the frame CRC and sequence checker.
// Holds the CRC-8 mask table, built at elaboration time. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcsc_pkg;

    localparam int WORD_BITS            = 40;
    localparam int CRC_BITS             = 8;
    localparam int L1_BITS              = 8;
    localparam int TOTAL_BITS           = 32;
    localparam int COUNTER_BITS_DEFAULT = 32;

    localparam logic [14:0]         SYNC_PATTERN = 15'h3C5C;
    localparam logic [CRC_BITS-1:0] CRC_POLY     = 8'h07;

    localparam logic [1:0] SEL_HEADER = 2'd0;
    localparam logic [1:0] SEL_FILLER = 2'd2;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_TRAILER = 3'd2,
        KIND_FILLER  = 3'd3,
        KIND_UNKNOWN = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OUTCOME_NONE     = 2'd0,
        OUTCOME_MATCH    = 2'd1,
        OUTCOME_MISMATCH = 2'd2
    } outcome_t;

    // Per-item increment requests for the eight statistics counters.
    typedef struct packed {
        logic header;
        logic data;
        logic trailer;
        logic filler;
        logic unknown;
        logic jump;
        logic match;
        logic mismatch;
    } count_inc_t;

    localparam int CRC_IN_BITS = CRC_BITS + WORD_BITS;

    // The CRC over one word is linear in {start, word}. Run the bitwise
    // MSB-first update on each unit vector to find which input bits feed
    // each CRC output bit.
    function automatic logic [CRC_BITS-1:0][CRC_IN_BITS-1:0] crc_mask_calc();
        logic [CRC_BITS-1:0][CRC_IN_BITS-1:0] mask;
        logic [CRC_IN_BITS-1:0]               vec;
        logic [CRC_BITS-1:0]                  crc;
        logic                                 fb;
        mask = '0;
        for (int i = 0; i < CRC_IN_BITS; i++) begin
            vec = '0;
            vec[i] = 1'b1;
            crc = vec[CRC_IN_BITS-1:WORD_BITS];
            for (int b = WORD_BITS - 1; b >= 0; b--) begin
                fb  = crc[CRC_BITS-1] ^ vec[b];
                crc = {crc[CRC_BITS-2:0], 1'b0};
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            for (int j = 0; j < CRC_BITS; j++) begin
                mask[j][i] = crc[j];
            end
        end
        return mask;
    endfunction

    localparam logic [CRC_BITS-1:0][CRC_IN_BITS-1:0] CRC_MASK = crc_mask_calc();

endpackage

`default_nettype wire

// File: design/fcsc_crc.sv
// CRC-8 (polynomial 0x07) over one 40-bit word, MSB first, from a given start.
// Each output bit is the parity of a masked input; uses fcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcsc_crc
(
    input  wire logic [fcsc_pkg::WORD_BITS-1:0] word,
    input  wire logic [fcsc_pkg::CRC_BITS-1:0]  crc_start,
    output logic      [fcsc_pkg::CRC_BITS-1:0]  crc_result
);

    logic [fcsc_pkg::CRC_IN_BITS-1:0] crc_in;

    assign crc_in = {crc_start, word};

    always_comb
    begin
        for (int j = 0; j < fcsc_pkg::CRC_BITS; j++) begin
            crc_result[j] = ^(crc_in & fcsc_pkg::CRC_MASK[j]);
        end
    end

endmodule

`default_nettype wire

// File: design/fcsc_sat_counter.sv
// Saturating event counter, COUNTER_BITS wide, cleared by reset.
// Standalone; width comes from the top level.
`timescale 1ns / 1ps
`default_nettype none

module fcsc_sat_counter
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    inc,
    output logic      [COUNTER_BITS-1:0] count
);

    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (inc && (count_reg != {COUNTER_BITS{1'b1}})) begin
            count_next = count_reg + COUNTER_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// File: design/frame_crc_and_sequence_checker.sv
// Top level of the frame CRC and sequence checker.
// Uses fcsc_pkg, fcsc_crc and fcsc_sat_counter.
`timescale 1ns / 1ps
`default_nettype none

// The checker takes one 40-bit link frame word per cycle and returns one
// result word per frame word, in order. A frame word is registered on
// acceptance, classified and checked from the input register, and its
// result is registered in the result register once that register is free;
// it then stays on the result channel until the receiver takes it. The
// sustained rate is one word per cycle; the only thing that can slow it is
// stall on the result side. The input register and the result register form
// a two-deep pipeline, so a new frame word is still taken while a finished
// result waits. Bit 39 marks a data word; otherwise the sync field selects
// header, filler or unknown, and any other sync value is a trailer. A header
// restarts the CRC-8 (polynomial 0x07, MSB first) and opens an event, and
// its L1 count is compared with the previous count plus one (the first
// header after reset is not compared). Data words extend the CRC only
// inside an open event, and a trailer inside an event compares its low byte
// with the CRC and closes the event. The running CRC and the eight
// saturating totals shown with a result are the values after that word.
// Totals are COUNTER_BITS wide internally; the ports carry their low 32
// bits, zero-extended when the counters are narrower.
module frame_crc_and_sequence_checker
#(
    parameter int COUNTER_BITS = fcsc_pkg::COUNTER_BITS_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                frame_valid,
    output logic                                     frame_stall,
    input  wire logic [fcsc_pkg::WORD_BITS-1:0]      frame_word,

    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic      [2:0]                          frame_kind,
    output logic      [1:0]                          check_outcome,
    output logic                                     sequence_jump,
    output logic      [fcsc_pkg::CRC_BITS-1:0]       running_crc,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     header_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     data_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     trailer_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     filler_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     unknown_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     jump_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     match_total,
    output logic      [fcsc_pkg::TOTAL_BITS-1:0]     mismatch_total
);

    // Input register stage.
    logic                               word_valid_reg;
    logic                               word_valid_next;
    logic [fcsc_pkg::WORD_BITS-1:0]     word_reg;

    // Result register stage.
    logic                               result_valid_reg;
    logic                               result_valid_next;
    fcsc_pkg::kind_t                    kind_reg;
    fcsc_pkg::outcome_t                 outcome_reg;
    logic                               jump_reg;

    // Checker state.
    logic                               event_open_reg;
    logic                               event_open_next;
    logic [fcsc_pkg::CRC_BITS-1:0]      crc_reg;
    logic [fcsc_pkg::CRC_BITS-1:0]      crc_next;
    logic [fcsc_pkg::L1_BITS-1:0]       previous_l1_reg;
    logic [fcsc_pkg::L1_BITS-1:0]       previous_l1_next;
    logic                               awaiting_first_reg;
    logic                               awaiting_first_next;

    // Processing-stage signals.
    logic                               advance;
    logic                               process;
    logic                               frame_accept;
    fcsc_pkg::kind_t                    kind_calc;
    fcsc_pkg::outcome_t                 outcome_calc;
    logic                               jump_calc;
    logic [fcsc_pkg::L1_BITS-1:0]       l1_count;
    logic [fcsc_pkg::L1_BITS-1:0]       l1_expect;
    logic [fcsc_pkg::CRC_BITS-1:0]      crc_start;
    logic [fcsc_pkg::CRC_BITS-1:0]      crc_word;
    fcsc_pkg::count_inc_t               count_inc;

    logic [COUNTER_BITS-1:0]            header_count;
    logic [COUNTER_BITS-1:0]            data_count;
    logic [COUNTER_BITS-1:0]            trailer_count;
    logic [COUNTER_BITS-1:0]            filler_count;
    logic [COUNTER_BITS-1:0]            unknown_count;
    logic [COUNTER_BITS-1:0]            jump_count;
    logic [COUNTER_BITS-1:0]            match_count;
    logic [COUNTER_BITS-1:0]            mismatch_count;

    // The result register frees up when it is empty or being taken this
    // cycle; the word in the input register moves on exactly then.
    assign advance      = !result_valid_reg || !result_stall;
    assign process      = word_valid_reg && advance;
    assign frame_stall  = word_valid_reg && !advance;
    assign frame_accept = frame_valid && !frame_stall;

    // Sort the registered word by type.
    always_comb
    begin
        if (word_reg[39]) begin
            kind_calc = fcsc_pkg::KIND_DATA;
        end else if (word_reg[38:24] != fcsc_pkg::SYNC_PATTERN) begin
            kind_calc = fcsc_pkg::KIND_TRAILER;
        end else begin
            unique case (word_reg[23:22])
                fcsc_pkg::SEL_HEADER: kind_calc = fcsc_pkg::KIND_HEADER;
                fcsc_pkg::SEL_FILLER: kind_calc = fcsc_pkg::KIND_FILLER;
                default:              kind_calc = fcsc_pkg::KIND_UNKNOWN;
            endcase
        end
    end

    // A header restarts the CRC from zero; a data word continues it.
    assign crc_start = (kind_calc == fcsc_pkg::KIND_HEADER) ? '0 : crc_reg;

    fcsc_crc u_crc
    (
        .word       (word_reg),
        .crc_start  (crc_start),
        .crc_result (crc_word)
    );

    assign l1_count  = word_reg[21:14];
    assign l1_expect = previous_l1_reg + fcsc_pkg::L1_BITS'(1);

    always_comb
    begin
        jump_calc = (kind_calc == fcsc_pkg::KIND_HEADER) && !awaiting_first_reg &&
                    (l1_count != l1_expect);

        outcome_calc = fcsc_pkg::OUTCOME_NONE;
        if ((kind_calc == fcsc_pkg::KIND_TRAILER) && event_open_reg) begin
            if (word_reg[fcsc_pkg::CRC_BITS-1:0] == crc_reg) begin
                outcome_calc = fcsc_pkg::OUTCOME_MATCH;
            end else begin
                outcome_calc = fcsc_pkg::OUTCOME_MISMATCH;
            end
        end
    end

    // State updates, applied only when the word moves into the result register.
    always_comb
    begin
        event_open_next     = event_open_reg;
        crc_next            = crc_reg;
        previous_l1_next    = previous_l1_reg;
        awaiting_first_next = awaiting_first_reg;
        if (process) begin
            case (kind_calc)
                fcsc_pkg::KIND_HEADER:
                begin
                    crc_next            = crc_word;
                    event_open_next     = 1'b1;
                    previous_l1_next    = l1_count;
                    awaiting_first_next = 1'b0;
                end
                fcsc_pkg::KIND_DATA:
                begin
                    if (event_open_reg) begin
                        crc_next = crc_word;
                    end
                end
                fcsc_pkg::KIND_TRAILER:
                begin
                    event_open_next = 1'b0;
                end
                default:
                begin
                    // Fillers and unknown words are only counted.
                end
            endcase
        end
    end

    always_comb
    begin
        count_inc.header   = process && (kind_calc == fcsc_pkg::KIND_HEADER);
        count_inc.data     = process && (kind_calc == fcsc_pkg::KIND_DATA);
        count_inc.trailer  = process && (kind_calc == fcsc_pkg::KIND_TRAILER);
        count_inc.filler   = process && (kind_calc == fcsc_pkg::KIND_FILLER);
        count_inc.unknown  = process && (kind_calc == fcsc_pkg::KIND_UNKNOWN);
        count_inc.jump     = process && jump_calc;
        count_inc.match    = process && (outcome_calc == fcsc_pkg::OUTCOME_MATCH);
        count_inc.mismatch = process && (outcome_calc == fcsc_pkg::OUTCOME_MISMATCH);
    end

    always_comb
    begin
        word_valid_next = word_valid_reg;
        if (frame_accept) begin
            word_valid_next = 1'b1;
        end else if (advance) begin
            word_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (process) begin
            result_valid_next = 1'b1;
        end else if (!result_stall) begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            event_open_reg     <= 1'b0;
            crc_reg            <= '0;
            previous_l1_reg    <= '0;
            awaiting_first_reg <= 1'b1;
        end else begin
            word_valid_reg     <= word_valid_next;
            result_valid_reg   <= result_valid_next;
            event_open_reg     <= event_open_next;
            crc_reg            <= crc_next;
            previous_l1_reg    <= previous_l1_next;
            awaiting_first_reg <= awaiting_first_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (frame_accept) begin
            word_reg <= frame_word;
        end
        if (process) begin
            kind_reg    <= kind_calc;
            outcome_reg <= outcome_calc;
            jump_reg    <= jump_calc;
        end
    end

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_header_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.header),
        .count (header_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_data_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.data),
        .count (data_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_trailer_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.trailer),
        .count (trailer_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_filler_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.filler),
        .count (filler_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_unknown_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.unknown),
        .count (unknown_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_jump_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.jump),
        .count (jump_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_match_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.match),
        .count (match_count)
    );

    fcsc_sat_counter #(.COUNTER_BITS(COUNTER_BITS)) u_mismatch_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (count_inc.mismatch),
        .count (mismatch_count)
    );

    // State only moves when a word enters the result register, so while a
    // result is held the CRC and counter registers still show the values
    // after that word and can drive the ports directly.
    assign result_valid   = result_valid_reg;
    assign frame_kind     = kind_reg;
    assign check_outcome  = outcome_reg;
    assign sequence_jump  = jump_reg;
    assign running_crc    = crc_reg;
    assign header_total   = (fcsc_pkg::TOTAL_BITS)'(header_count);
    assign data_total     = (fcsc_pkg::TOTAL_BITS)'(data_count);
    assign trailer_total  = (fcsc_pkg::TOTAL_BITS)'(trailer_count);
    assign filler_total   = (fcsc_pkg::TOTAL_BITS)'(filler_count);
    assign unknown_total  = (fcsc_pkg::TOTAL_BITS)'(unknown_count);
    assign jump_total     = (fcsc_pkg::TOTAL_BITS)'(jump_count);
    assign match_total    = (fcsc_pkg::TOTAL_BITS)'(match_count);
    assign mismatch_total = (fcsc_pkg::TOTAL_BITS)'(mismatch_count);

    // A CRC check outcome belongs to trailers only.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (outcome_reg != fcsc_pkg::OUTCOME_NONE)
            |-> (kind_reg == fcsc_pkg::KIND_TRAILER))
        else $error("check outcome reported on a word that is not a trailer");

    // A sequence jump belongs to headers only.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && jump_reg |-> (kind_reg == fcsc_pkg::KIND_HEADER))
        else $error("sequence jump reported on a word that is not a header");

    // A processed header always leaves an event open.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && (kind_calc == fcsc_pkg::KIND_HEADER) |=> event_open_reg)
        else $error("event not open after a header");

    // The input side is held off only when both pipeline registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (word_valid_reg && result_valid_reg && result_stall))
        else $error("frame input stalled while the pipeline has room");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for frame_crc_and_sequence_checker: frame words in, one result each.
// Depends on fcsc_pkg for the kind and outcome codes, the sync pattern and the CRC polynomial.
// Also needs the checker and its submodules; random values come from the simulator seed.
`timescale 1ns / 1ps

module tb_top;

    import fcsc_pkg::*;

    // The run offers this many frame words in total. The directed table comes
    // first and the random words follow.
    localparam int NUM_DIRECTED = 22;
    localparam int TOTAL_WORDS  = 1550;

    // Idle and stall odds, in percent, outside the quiet stretch.
    localparam int IDLE_PERCENT = 27;

    // The receiver holds off once, for a long stretch, after this many words
    // have gone in. The quiet stretch, with no idling on either side, covers a
    // band of accepted words later in the run.
    localparam int HOLD_AFTER_WORDS = 300;
    localparam int HOLD_CYCLES      = 80;
    localparam int QUIET_FIRST      = 900;
    localparam int QUIET_LAST       = 1100;

    // Positions of the check totals in the totals vector. The five type
    // totals sit at the positions of their kind codes.
    localparam int TOT_JUMP     = 5;
    localparam int TOT_MATCH    = 6;
    localparam int TOT_MISMATCH = 7;

    // The two selector values that mark an unknown frame.
    localparam logic [1:0] SEL_UNKNOWN_LO = 2'd1;
    localparam logic [1:0] SEL_UNKNOWN_HI = 2'd3;

    // A trailer row in the directed table can have its low byte replaced by
    // the running CRC (a good trailer) or its inverse (a bad one) when it is
    // put on the bus, since the CRC depends on everything sent before.
    typedef enum logic [1:0] {
        FIX_NONE,
        FIX_MATCH,
        FIX_MISMATCH
    } trailer_fix_t;

    // One row of the directed table. When typed is set, the kind, outcome and
    // jump flag written in the row are what the checker must return; the CRC
    // and the totals always come from the predictor.
    typedef struct {
        logic [WORD_BITS-1:0] word;
        trailer_fix_t         fix;
        bit                   typed;
        kind_t                kind;
        outcome_t             outcome;
        bit                   jump;
    } stim_row_t;

    // Everything the checker returns for one frame word.
    typedef struct packed {
        kind_t                         kind;
        outcome_t                      outcome;
        logic                          jump;
        logic [CRC_BITS-1:0]           crc;
        logic [7:0][TOTAL_BITS-1:0]    totals;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Every input of the checker holds a known value from time zero.
    logic                    frame_valid = 1'b0;
    logic [WORD_BITS-1:0]    frame_word = '0;
    logic                    result_stall = 1'b0;

    logic                    frame_stall;
    logic                    result_valid;
    logic [2:0]              frame_kind;
    logic [1:0]              check_outcome;
    logic                    sequence_jump;
    logic [CRC_BITS-1:0]     running_crc;
    logic [TOTAL_BITS-1:0]   header_total;
    logic [TOTAL_BITS-1:0]   data_total;
    logic [TOTAL_BITS-1:0]   trailer_total;
    logic [TOTAL_BITS-1:0]   filler_total;
    logic [TOTAL_BITS-1:0]   unknown_total;
    logic [TOTAL_BITS-1:0]   jump_total;
    logic [TOTAL_BITS-1:0]   match_total;
    logic [TOTAL_BITS-1:0]   mismatch_total;

    frame_crc_and_sequence_checker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_word     (frame_word),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .frame_kind     (frame_kind),
        .check_outcome  (check_outcome),
        .sequence_jump  (sequence_jump),
        .running_crc    (running_crc),
        .header_total   (header_total),
        .data_total     (data_total),
        .trailer_total  (trailer_total),
        .filler_total   (filler_total),
        .unknown_total  (unknown_total),
        .jump_total     (jump_total),
        .match_total    (match_total),
        .mismatch_total (mismatch_total)
    );

    // The directed table. It opens with a stray trailer and a stray data word
    // right after reset, then filler and both kinds of unknown frame, the first
    // header (whose count is never checked) with all low bits set, an all-ones
    // data word, a filler inside an event, a good trailer, a trailer outside
    // any event, the L1 count wrapping from 0xFF to 0x00, a header that
    // restarts an event that is still open, a bad trailer, two jumps in a row,
    // an event with no data at all, and a trailer with every bit set but bit 39.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{40'h00_0000_0000, FIX_NONE, 1'b1, KIND_TRAILER, OUTCOME_NONE, 1'b0},
        '{40'h80_0000_0000, FIX_NONE, 1'b1, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_FILLER, 22'h000000}, FIX_NONE, 1'b1,
          KIND_FILLER, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_UNKNOWN_LO, 22'h3FFFFF}, FIX_NONE, 1'b1,
          KIND_UNKNOWN, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_UNKNOWN_HI, 22'h155555}, FIX_NONE, 1'b1,
          KIND_UNKNOWN, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'hFF, 14'h3FFF}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b0},
        '{40'hFF_FFFF_FFFF, FIX_NONE, 1'b1, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{40'h80_0000_0000, FIX_NONE, 1'b0, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_FILLER, 22'h2AAAAA}, FIX_NONE, 1'b0,
          KIND_FILLER, OUTCOME_NONE, 1'b0},
        '{{1'b0, 15'h7FFF, 24'h000000}, FIX_MATCH, 1'b1,
          KIND_TRAILER, OUTCOME_MATCH, 1'b0},
        '{{1'b0, 15'h0000, 24'hFFFFFF}, FIX_NONE, 1'b1,
          KIND_TRAILER, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'h00, 14'h0000}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b0},
        '{40'hA5_5A5A_A5A5, FIX_NONE, 1'b0, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'h01, 14'h1555}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b0},
        '{40'h80_0000_0001, FIX_NONE, 1'b0, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{{1'b0, 15'h3C5D, 24'h000000}, FIX_MISMATCH, 1'b1,
          KIND_TRAILER, OUTCOME_MISMATCH, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'h40, 14'h0000}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b1},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'h40, 14'h2AAA}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b1},
        '{{1'b0, 15'h1234, 24'h000000}, FIX_MATCH, 1'b1,
          KIND_TRAILER, OUTCOME_MATCH, 1'b0},
        '{40'hC3_3C3C_C3C3, FIX_NONE, 1'b0, KIND_DATA, OUTCOME_NONE, 1'b0},
        '{{1'b0, SYNC_PATTERN, SEL_HEADER, 8'h41, 14'h0001}, FIX_NONE, 1'b1,
          KIND_HEADER, OUTCOME_NONE, 1'b0},
        '{40'h7F_FFFF_FFFF, FIX_NONE, 1'b0, KIND_TRAILER, OUTCOME_NONE, 1'b0}
    };

    // The predictor's own copy of the checker state.
    logic                          track_open = 1'b0;
    logic [CRC_BITS-1:0]           track_crc = '0;
    logic [L1_BITS-1:0]            track_prev_l1 = '0;
    logic                          track_first_pending = 1'b1;
    logic [7:0][TOTAL_BITS-1:0]    track_totals = '0;

    // Results still owed by the checker, oldest first.
    frame_result_t expected_results [$];

    int  words_offered = 0;
    int  words_accepted = 0;
    int  results_checked = 0;
    int  error_count = 0;
    bit  all_sent = 1'b0;

    // Data words still to come in the current random event.
    int  data_left = 0;

    // State of the receiver's long hold-off.
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // While this is high neither side idles.
    wire quiet_stretch = (words_accepted >= QUIET_FIRST) && (words_accepted < QUIET_LAST);

    // Free-running clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // CRC-8, polynomial 0x07, shifted in MSB first over all 40 bits of a word.
    function automatic logic [CRC_BITS-1:0] crc8_over_word(input logic [WORD_BITS-1:0] word,
                                                           input logic [CRC_BITS-1:0] seed);
        logic [CRC_BITS-1:0] c;
        logic                fb;
        c = seed;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            fb = c[CRC_BITS-1] ^ word[b];
            c  = {c[CRC_BITS-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Totals stop at all ones rather than wrapping.
    function automatic void bump_total(input int idx);
        if (track_totals[idx] != '1)
        begin
            track_totals[idx] = track_totals[idx] + 1'b1;
        end
    endfunction

    // Classifies one word, advances the predictor state and returns the
    // result the checker must give for it.
    function automatic frame_result_t predict_frame_result(input logic [WORD_BITS-1:0] word);
        frame_result_t      r;
        kind_t              k;
        logic [L1_BITS-1:0] l1;
        logic [L1_BITS-1:0] l1_next;
        r = '0;
        if (word[WORD_BITS-1])
        begin
            k = KIND_DATA;
        end
        else if (word[38:24] != SYNC_PATTERN)
        begin
            k = KIND_TRAILER;
        end
        else if (word[23:22] == SEL_HEADER)
        begin
            k = KIND_HEADER;
        end
        else if (word[23:22] == SEL_FILLER)
        begin
            k = KIND_FILLER;
        end
        else
        begin
            k = KIND_UNKNOWN;
        end
        bump_total(int'(k));
        r.outcome = OUTCOME_NONE;
        r.jump    = 1'b0;
        case (k)
            KIND_HEADER:
            begin
                l1        = word[21:14];
                l1_next   = track_prev_l1 + 1'b1;
                track_crc = crc8_over_word(word, '0);
                track_open = 1'b1;
                if (!track_first_pending && l1 != l1_next)
                begin
                    r.jump = 1'b1;
                    bump_total(TOT_JUMP);
                end
                track_prev_l1       = l1;
                track_first_pending = 1'b0;
            end
            KIND_DATA:
            begin
                if (track_open)
                begin
                    track_crc = crc8_over_word(word, track_crc);
                end
            end
            KIND_TRAILER:
            begin
                if (track_open)
                begin
                    if (word[7:0] == track_crc)
                    begin
                        r.outcome = OUTCOME_MATCH;
                        bump_total(TOT_MATCH);
                    end
                    else
                    begin
                        r.outcome = OUTCOME_MISMATCH;
                        bump_total(TOT_MISMATCH);
                    end
                    track_open = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.kind   = k;
        r.crc    = track_crc;
        r.totals = track_totals;
        return r;
    endfunction

    // Word shaping for the random part. The other bits keep their random
    // content so that every bit of the field sees both values.
    function automatic logic [WORD_BITS-1:0] shape_header(input logic [WORD_BITS-1:0] w,
                                                          input logic [L1_BITS-1:0] l1);
        w[WORD_BITS-1] = 1'b0;
        w[38:24]       = SYNC_PATTERN;
        w[23:22]       = SEL_HEADER;
        w[21:14]       = l1;
        return w;
    endfunction

    function automatic logic [WORD_BITS-1:0] shape_trailer(input logic [WORD_BITS-1:0] w,
                                                           input logic [7:0] low_byte);
        w[WORD_BITS-1] = 1'b0;
        if (w[38:24] == SYNC_PATTERN)
        begin
            w[24] = ~w[24];
        end
        w[7:0] = low_byte;
        return w;
    endfunction

    // A word that does not belong to a well-formed event: a stray data word,
    // a stray trailer, a filler or an unknown frame.
    function automatic logic [WORD_BITS-1:0] shape_noise(input logic [WORD_BITS-1:0] w);
        case ($urandom_range(0, 3))
            0:
            begin
                w[WORD_BITS-1] = 1'b1;
            end
            1:
            begin
                w = shape_trailer(w, w[7:0]);
            end
            2:
            begin
                w[WORD_BITS-1] = 1'b0;
                w[38:24]       = SYNC_PATTERN;
                w[23:22]       = SEL_FILLER;
            end
            default:
            begin
                w[WORD_BITS-1] = 1'b0;
                w[38:24]       = SYNC_PATTERN;
                w[23:22]       = ($urandom_range(0, 1) != 0) ? SEL_UNKNOWN_HI : SEL_UNKNOWN_LO;
            end
        endcase
        return w;
    endfunction

    // Picks the next random word. Most words form events: a header whose L1
    // count usually follows on, a few data words, then a trailer that usually
    // carries the right CRC. Noise, jumps, bad trailers and restarts are
    // mixed in at lower rates.
    function automatic logic [WORD_BITS-1:0] pick_random_word();
        logic [WORD_BITS-1:0] w;
        logic [L1_BITS-1:0]   l1;
        int unsigned          roll;
        w    = {8'($urandom), 32'($urandom)};
        roll = $urandom_range(0, 99);
        l1   = ($urandom_range(0, 99) < 85) ? L1_BITS'(track_prev_l1 + 1'b1)
                                            : L1_BITS'($urandom);
        if (data_left > 0)
        begin
            data_left--;
            if (roll < 88)
            begin
                w[WORD_BITS-1] = 1'b1;
            end
            else
            begin
                w = shape_noise(w);
            end
        end
        else if (track_open)
        begin
            if (roll < 70)
            begin
                w = shape_trailer(w, track_crc);
            end
            else if (roll < 85)
            begin
                w = shape_trailer(w, track_crc ^ 8'($urandom_range(1, 255)));
            end
            else if (roll < 93)
            begin
                w = shape_header(w, l1);
                data_left = $urandom_range(0, 5);
            end
            else
            begin
                w = shape_noise(w);
            end
        end
        else if (roll < 75)
        begin
            w = shape_header(w, l1);
            data_left = $urandom_range(0, 5);
        end
        else
        begin
            w = shape_noise(w);
        end
        return w;
    endfunction

    // Compares one field of a result and reports a difference.
    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // Sender. At each rising edge it first notes whether the word on the bus
    // was taken; if so, the predictor works out that word's result at once,
    // so the state it leaves behind is current when the next word is built.
    // A trailer row in the table reads the running CRC at this point. A new
    // word, or an idle cycle, follows only when the bus is free; a stalled
    // word stays on the bus unchanged. Each input gets at most one
    // nonblocking assignment per edge.
    always @(posedge clk)
    begin : drive_frames
        frame_result_t        predicted;
        logic [WORD_BITS-1:0] next_word;
        stim_row_t            row;
        static bit            pending_typed = 1'b0;
        static kind_t         pending_kind = KIND_HEADER;
        static outcome_t      pending_outcome = OUTCOME_NONE;
        static bit            pending_jump = 1'b0;
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
            begin
                predicted = predict_frame_result(frame_word);
                if (pending_typed)
                begin
                    predicted.kind    = pending_kind;
                    predicted.outcome = pending_outcome;
                    predicted.jump    = pending_jump;
                end
                expected_results = {expected_results, predicted};
                words_accepted <= words_accepted + 1;
                if (words_offered == TOTAL_WORDS)
                begin
                    all_sent <= 1'b1;
                end
            end
            if (!frame_valid || !frame_stall)
            begin
                if (words_offered == TOTAL_WORDS ||
                    (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT))
                begin
                    frame_valid <= 1'b0;
                end
                else
                begin
                    if (words_offered < NUM_DIRECTED)
                    begin
                        row       = directed_rows[words_offered];
                        next_word = row.word;
                        if (row.fix == FIX_MATCH)
                        begin
                            next_word[7:0] = track_crc;
                        end
                        else if (row.fix == FIX_MISMATCH)
                        begin
                            next_word[7:0] = ~track_crc;
                        end
                        pending_typed   = row.typed;
                        pending_kind    = row.kind;
                        pending_outcome = row.outcome;
                        pending_jump    = row.jump;
                    end
                    else
                    begin
                        next_word     = pick_random_word();
                        pending_typed = 1'b0;
                    end
                    frame_word  <= next_word;
                    frame_valid <= 1'b1;
                    words_offered++;
                end
            end
        end
    end

    // Receiver stall. It stalls at random, except in the quiet stretch, and
    // once holds off for a long run of cycles, counted here, while the sender
    // keeps offering words. The checker's two-deep pipeline then fills and
    // must stall its input without losing or repeating a word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (!hold_done && words_accepted >= HOLD_AFTER_WORDS)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Result checker. Every result taken off the bus is matched against the
    // oldest expectation, field by field; a result with nothing owed is an
    // error in itself.
    always @(posedge clk)
    begin : check_results
        frame_result_t              want;
        logic [7:0][TOTAL_BITS-1:0] seen_totals;
        string                      total_names [8];
        total_names = '{"header_total", "data_total", "trailer_total", "filler_total",
                        "unknown_total", "jump_total", "match_total", "mismatch_total"};
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result with no word outstanding, expected none, actual kind %0h",
                         $time, frame_kind);
            end
            else
            begin
                want = expected_results.pop_front();
                seen_totals = {mismatch_total, match_total, jump_total, unknown_total,
                               filler_total, trailer_total, data_total, header_total};
                compare_field("frame_kind", 32'(want.kind), 32'(frame_kind));
                compare_field("check_outcome", 32'(want.outcome), 32'(check_outcome));
                compare_field("sequence_jump", 32'(want.jump), 32'(sequence_jump));
                compare_field("running_crc", 32'(want.crc), 32'(running_crc));
                for (int i = 0; i < 8; i++)
                begin
                    compare_field(total_names[i], want.totals[i], seen_totals[i]);
                end
                results_checked++;
            end
        end
    end

    // Reset, then wait for every word to go in and every result to come out,
    // then allow a few more cycles so that a stray extra result is caught.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (!(all_sent && expected_results.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        $display("Run summary: %0d words offered, %0d results checked, %0d errors.",
                 words_accepted, results_checked, error_count);
        $display("Seen: %0d headers, %0d data, %0d trailers, %0d filler, %0d unknown,",
                 track_totals[int'(KIND_HEADER)], track_totals[int'(KIND_DATA)],
                 track_totals[int'(KIND_TRAILER)], track_totals[int'(KIND_FILLER)],
                 track_totals[int'(KIND_UNKNOWN)]);
        $display("      %0d jumps, %0d good and %0d bad CRCs.",
                 track_totals[TOT_JUMP], track_totals[TOT_MATCH], track_totals[TOT_MISMATCH]);
        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog. A run that hangs is stopped here and reported as a failure.
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results still owed.", expected_results.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: frame_crc_and_sequence_checker.f
design/fcsc_pkg.sv
design/fcsc_crc.sv
design/fcsc_sat_counter.sv
design/frame_crc_and_sequence_checker.sv
test/tb_top.sv
